>>> rtl/emt_pkg.sv
// ----------------------------------------------------------------------------
// emt_pkg: shared types and constants for the extent map table
// Holds the word structs, status codes, opcodes, the cell flags struct and the sequencer states.
// ----------------------------------------------------------------------------
package emt_pkg;

  localparam int MaxExtents = 4;
  localparam int IdxW = $clog2(MaxExtents);
  localparam int CntW = $clog2(MaxExtents + 1);
  localparam logic [14:0] MaxLen = 15'd32767;

  typedef enum logic [1:0] {
    OP_LOOKUP   = 2'd0,
    OP_INSERT   = 2'd1,
    OP_TRUNCATE = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_MISS     = 3'd1,
    ST_MERGED   = 3'd2,
    ST_INSERTED = 3'd3,
    ST_FULL     = 3'd4,
    ST_FREED    = 3'd5,
    ST_DONE     = 3'd6
  } status_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] logical_block;
    logic [31:0] physical_block;
    logic [31:0] cut_block;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] mapped_block;
    logic [14:0] freed_count;
    logic [2:0]  entries_left;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic [31:0] start;
    logic [14:0] length;
    logic [31:0] physical;
  } extent_t;

  // per-cell flags produced from the broadcast request
  typedef struct packed {
    logic        hit;
    logic        merge;
    logic        after;   // new block sorts before this entry
    logic        freed;   // some blocks of this entry are at or past cut
    logic        keep;    // entry survives truncate
    logic [31:0] fblk;
    logic [14:0] fcnt;
    logic [31:0] hblk;
  } cell_flags_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_EMIT
  } state_t;

endpackage

>>> rtl/extent_map_table_unit.sv
// ----------------------------------------------------------------------------
// extent_map_table_unit: sorted extent table with lookup, insert, truncate
// Top level: a chain of entry cells plus the sequencer that drives them.
// ----------------------------------------------------------------------------
// Use: present a request word on in_word with in_valid; it is taken at an
// edge where in_stall is low. Results leave on out_word/out_valid and are
// taken where out_stall is low; out_word.last marks the final word of a
// request. Lookup and insert give one word, truncate gives one word per
// freed range and a closing word.
// Timing: a request is taken in idle, evaluated against every cell in
// parallel in the next cycle, and its first word is shown the cycle after.
// Truncate words follow one another as each is taken. The next request is
// taken in the cycle after the last word leaves. One request is in flight
// at a time since each depends on the table the previous one left; the
// loop that sets this is the cell compare and table update.
// Reset: entry count clears to zero, capacity goes to 4; entry contents are
// not cleared. A stalled output word holds until taken.
// Opcode 3 is dropped and gives no word.
// ----------------------------------------------------------------------------
module extent_map_table_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  emt_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output emt_pkg::out_word_t out_word,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_data
);

  localparam int N = emt_pkg::MaxExtents;
  localparam int IW = emt_pkg::IdxW;
  localparam int CW = emt_pkg::CntW;

  emt_pkg::state_t state_r, state_nxt;
  emt_pkg::in_word_t req_r;
  logic [2:0] cap_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  emt_pkg::out_word_t q_r [N+1];
  emt_pkg::out_word_t q_nxt [N+1];
  logic [CW-1:0] qn_r, qn_nxt, qi_r, qi_nxt;

  emt_pkg::extent_t ext [N];
  emt_pkg::extent_t left_ext [N];
  emt_pkg::extent_t pick_ext [N];
  emt_pkg::cell_flags_t flags [N];
  logic [1:0] sel [N];
  logic grow [N];
  logic valid [N];

  logic take_in, take_out, eval;
  logic [CW-1:0] cap_eff;

  assign take_in = in_valid && !in_stall;
  assign take_out = out_valid && !out_stall;
  assign eval = (state_r == emt_pkg::S_EVAL);
  assign cap_eff = (cap_r > 3'(N)) ? CW'(N) : CW'(cap_r);

  for (genvar g = 0; g < N; g++) begin : g_cell
    assign valid[g] = (CW'(g) < cnt_r);
    assign left_ext[g] = (g == 0) ? ext[0] : ext[(g == 0) ? 0 : g - 1];
    emt_cell u_cell (
      .clk(clk), .req(req_r), .valid(valid[g]), .left_ext(left_ext[g]),
      .pick_ext(pick_ext[g]), .sel(sel[g]), .grow(grow[g]),
      .ext(ext[g]), .flags(flags[g])
    );
  end

  // Resolve the request across the chain: first hit, first merge, insert
  // position, and truncate compaction (kept entries are a prefix anyway,
  // since the table is sorted, so only the cut entry shortens).
  always_comb begin
    logic found, merged, posf;
    logic [IW-1:0] pos;
    logic [CW-1:0] nf, kept;
    emt_pkg::out_word_t w;
    found = 1'b0; merged = 1'b0; posf = 1'b0;
    pos = '0; nf = '0; kept = '0;
    w = '0;
    cnt_nxt = cnt_r;
    qn_nxt = qn_r;
    qi_nxt = qi_r;
    for (int k = 0; k <= N; k++) q_nxt[k] = q_r[k];
    for (int k = 0; k < N; k++) begin
      sel[k] = 2'd0; grow[k] = 1'b0; pick_ext[k] = ext[k];
    end
    if (take_out) qi_nxt = qi_r + CW'(1);
    if (state_r == emt_pkg::S_IDLE) begin
      qi_nxt = '0;
    end
    if (eval) begin
      qi_nxt = '0;
      unique case (emt_pkg::op_t'(req_r.opcode))
        emt_pkg::OP_LOOKUP: begin
          w.status = emt_pkg::ST_MISS;
          for (int k = 0; k < N; k++)
            if (flags[k].hit && !found) begin
              found = 1'b1;
              w.status = emt_pkg::ST_HIT;
              w.mapped_block = flags[k].hblk;
            end
          w.entries_left = 3'(cnt_r);
          w.last = 1'b1;
          q_nxt[0] = w; qn_nxt = CW'(1);
        end
        emt_pkg::OP_INSERT: begin
          for (int k = 0; k < N; k++) begin
            if (flags[k].merge && !merged) begin
              merged = 1'b1;
              grow[k] = 1'b1;
            end
            if (!merged && flags[k].after && !posf) begin
              posf = 1'b1; pos = IW'(k);
            end
          end
          w.entries_left = 3'(cnt_r);
          w.last = 1'b1;
          if (merged) begin
            w.status = emt_pkg::ST_MERGED;
            w.mapped_block = req_r.physical_block;
          end else if (cnt_r >= cap_eff) begin
            w.status = emt_pkg::ST_FULL;
          end else begin
            w.status = emt_pkg::ST_INSERTED;
            w.mapped_block = req_r.physical_block;
            w.entries_left = 3'(cnt_r + CW'(1));
            cnt_nxt = cnt_r + CW'(1);
            for (int k = 0; k < N; k++) begin
              if (CW'(k) <= cnt_r) begin
                if (posf && IW'(k) == pos) sel[k] = 2'd2;
                else if (posf && IW'(k) > pos) sel[k] = 2'd1;
                else if (!posf && CW'(k) == cnt_r) sel[k] = 2'd2;
              end
            end
          end
          q_nxt[0] = w; qn_nxt = CW'(1);
        end
        emt_pkg::OP_TRUNCATE: begin
          for (int k = 0; k < N; k++) begin
            if (flags[k].keep) begin
              kept = kept + CW'(1);
              if (flags[k].freed) begin
                grow[k] = 1'b0;
                sel[k] = 2'd3;
                pick_ext[k].length = ext[k].length - flags[k].fcnt;
              end
            end
          end
          for (int k = 0; k < N; k++) begin
            if (flags[k].freed) begin
              q_nxt[nf] = '{status: emt_pkg::ST_FREED, mapped_block: flags[k].fblk,
                            freed_count: flags[k].fcnt, entries_left: 3'(kept),
                            last: 1'b0};
              nf = nf + CW'(1);
            end
          end
          q_nxt[nf] = '{status: emt_pkg::ST_DONE, mapped_block: 32'd0,
                        freed_count: 15'd0, entries_left: 3'(kept), last: 1'b1};
          qn_nxt = nf + CW'(1);
          cnt_nxt = kept;
        end
        default: qn_nxt = '0;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      emt_pkg::S_IDLE: if (take_in) state_nxt = emt_pkg::S_EVAL;
      emt_pkg::S_EVAL: state_nxt = (qn_nxt == '0) ? emt_pkg::S_IDLE : emt_pkg::S_EMIT;
      emt_pkg::S_EMIT:
        if (take_out && out_word.last) state_nxt = emt_pkg::S_IDLE;
      default: state_nxt = emt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state_r != emt_pkg::S_IDLE);
    out_valid = (state_r == emt_pkg::S_EMIT);
    out_word = q_r[0];
    for (int k = 0; k <= N; k++)
      if (CW'(k) == qi_r) out_word = q_r[k];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= emt_pkg::S_IDLE;
      cnt_r <= '0;
      cap_r <= 3'd4;
      qn_r <= '0;
      qi_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      qn_r <= qn_nxt;
      qi_r <= qi_nxt;
      if (cfg_we) cap_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) req_r <= in_word;
    for (int k = 0; k <= N; k++) q_r[k] <= q_nxt[k];
  end

  // output word index never runs past the filled words
  a_qi: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (qi_r < qn_r)) else $error("output index past end");
  // entry count never exceeds table size
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(N)) else $error("entry count overflow");
  // no new request accepted while words are pending
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("accept while busy");

endmodule

>>> rtl/emt_cell.sv
// ----------------------------------------------------------------------------
// emt_cell: one extent entry of the table
// Compares its entry against the request and loads from itself, its left
// neighbor, the new word or the compaction source, as the control selects.
// ----------------------------------------------------------------------------
module emt_cell (
  input  logic                clk,
  input  emt_pkg::in_word_t   req,
  input  logic                valid,
  input  emt_pkg::extent_t    left_ext,
  input  emt_pkg::extent_t    pick_ext,   // compaction source for truncate
  input  logic [1:0]          sel,        // 0 hold,1 shift,2 load new,3 pick
  input  logic                grow,
  output emt_pkg::extent_t    ext,
  output emt_pkg::cell_flags_t flags
);

  emt_pkg::extent_t ext_r, ext_nxt;
  logic [32:0] s_end, p_end;
  logic [31:0] keep_len;

  assign ext = ext_r;

  always_comb begin
    s_end = {1'b0, ext_r.start} + {18'd0, ext_r.length};
    p_end = {1'b0, ext_r.physical} + {18'd0, ext_r.length};
    keep_len = req.cut_block - ext_r.start;
    flags.hit = valid && (req.logical_block >= ext_r.start) &&
                ({1'b0, req.logical_block} < s_end);
    flags.hblk = ext_r.physical + (req.logical_block - ext_r.start);
    flags.merge = valid && (s_end == {1'b0, req.logical_block}) &&
                  (p_end == {1'b0, req.physical_block}) &&
                  (ext_r.length < emt_pkg::MaxLen);
    flags.after = valid && (req.logical_block < ext_r.start);
    flags.keep = valid && (ext_r.start < req.cut_block);
    flags.freed = valid && (!flags.keep || (s_end > {1'b0, req.cut_block}));
    flags.fblk = flags.keep ? ext_r.physical + keep_len : ext_r.physical;
    flags.fcnt = flags.keep ? ext_r.length - keep_len[14:0] : ext_r.length;
  end

  always_comb begin
    ext_nxt = ext_r;
    unique case (sel)
      2'd0: ext_nxt = ext_r;
      2'd1: ext_nxt = left_ext;
      2'd2: ext_nxt = '{start: req.logical_block, length: 15'd1,
                        physical: req.physical_block};
      2'd3: ext_nxt = pick_ext;
      default: ext_nxt = ext_r;
    endcase
    if (grow) ext_nxt.length = ext_r.length + 15'd1;
  end

  always_ff @(posedge clk) begin
    ext_r <= ext_nxt;
  end

endmodule
